// ===== sv/psds_pkg.sv =====
// ----------------------------------------------------------------------------
// psds_pkg
// Shared types and codes for the pixel square-difference similarity block.
// ----------------------------------------------------------------------------
package psds_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned DIFF_W    = 16;
    localparam int unsigned MAP_W     = 16;
    localparam int unsigned ROOT_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 13;

    localparam logic [MAP_W-1:0] FULL_SCALE = 16'd65280;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_DAT_W-1:0] DIM_RESET = 13'd64;

    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        logic              last;
        logic              err;
    } psds_item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQRT,
        BK_ACC,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

// ===== sv/psds_front.sv =====
// ----------------------------------------------------------------------------
// psds_front
// Accepts pixel pairs, forms |ref^2 - test^2|, tracks the frame position and
// holds the frame size registers.
// ----------------------------------------------------------------------------
module psds_front #(
    parameter int unsigned MAX_FRAME_DIM = 4096,
    parameter int unsigned MIN_FRAME_DIM = 16,
    parameter int unsigned CNT_W         = 24,
    parameter int unsigned TOT_W         = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [2*psds_pkg::PIX_W-1:0]      s_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psds_pkg::CFG_DAT_W-1:0]    cfg_data,
    output logic                              push,
    output psds_pkg::psds_item_t              push_item,
    input  logic                              full,
    output logic [TOT_W-1:0]                  total
);
    import psds_pkg::*;

    localparam int unsigned DIM_W = $clog2(MAX_FRAME_DIM + 1);

    logic [CFG_DAT_W-1:0] width_reg, width_next;
    logic [CFG_DAT_W-1:0] height_reg, height_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [31:0]          w_ext, h_ext, w_cl, h_cl;
    logic [DIM_W-1:0]     width_cl, height_cl;
    logic [2*DIM_W-1:0]   prod;
    logic [TOT_W:0]       cnt_inc;
    logic                 last;
    logic                 err;
    logic [PIX_W-1:0]     ref_pix, test_pix;
    logic [DIFF_W-1:0]    r2, t2;
    logic                 accept;

    assign s_axis_tready = !full;
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        w_ext = 32'(width_reg);
        h_ext = 32'(height_reg);
        if (w_ext == 32'd0)
        begin
            w_cl = 32'd1;
        end
        else if (w_ext > MAX_FRAME_DIM)
        begin
            w_cl = MAX_FRAME_DIM;
        end
        else
        begin
            w_cl = w_ext;
        end
        if (h_ext == 32'd0)
        begin
            h_cl = 32'd1;
        end
        else if (h_ext > MAX_FRAME_DIM)
        begin
            h_cl = MAX_FRAME_DIM;
        end
        else
        begin
            h_cl = h_ext;
        end
    end

    assign width_cl  = DIM_W'(w_cl);
    assign height_cl = DIM_W'(h_cl);
    assign prod      = (2*DIM_W)'(width_cl) * (2*DIM_W)'(height_cl);
    assign total     = TOT_W'(prod);

    assign cnt_inc = (TOT_W+1)'(cnt_reg) + (TOT_W+1)'(1);
    assign last    = cnt_inc >= {1'b0, total};
    assign err     = (32'(width_reg) < MIN_FRAME_DIM) || (32'(height_reg) < MIN_FRAME_DIM);

    assign ref_pix  = s_axis_tdata[PIX_W-1:0];
    assign test_pix = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign r2       = DIFF_W'(ref_pix) * DIFF_W'(ref_pix);
    assign t2       = DIFF_W'(test_pix) * DIFF_W'(test_pix);

    assign push           = accept;
    assign push_item.diff = (r2 >= t2) ? (r2 - t2) : (t2 - r2);
    assign push_item.last = last;
    assign push_item.err  = err;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  width_next  = cfg_data;
                CFG_FRAME_HEIGHT: height_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = last ? '0 : CNT_W'(cnt_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            cnt_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== sv/psds_fifo.sv =====
// ----------------------------------------------------------------------------
// psds_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module psds_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  psds_pkg::psds_item_t push_item,
    input  logic                 pop,
    output psds_pkg::psds_item_t pop_item,
    output logic                 full,
    output logic                 empty
);
    import psds_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    psds_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== sv/psds_back.sv =====
// ----------------------------------------------------------------------------
// psds_back
// Runs the bit-serial square root, accumulates map values, divides the frame
// sum at the end of a frame without a size error and holds the result beat.
// ----------------------------------------------------------------------------
module psds_back #(
    parameter int unsigned CNT_W = 24,
    parameter int unsigned TOT_W = 25
) (
    input  logic                     clk,
    input  logic                     rst_n,
    output logic                     pop,
    input  psds_pkg::psds_item_t     pop_item,
    input  logic                     empty,
    input  logic [TOT_W-1:0]         total,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [2*psds_pkg::MAP_W-1:0] m_axis_tdata,
    output logic [1:0]               m_axis_tuser
);
    import psds_pkg::*;

    localparam int unsigned SUM_W  = CNT_W + MAP_W;
    localparam int unsigned RAD_W  = 2 * ROOT_W;
    localparam int unsigned SREM_W = ROOT_W + 2;
    localparam int unsigned STEP_W = $clog2(SUM_W);

    back_state_t         st_reg, st_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [SREM_W-1:0]   srem_reg, srem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]    dvd_reg, dvd_next;
    logic [TOT_W:0]      drem_reg, drem_next;
    logic                last_reg, last_next;
    logic                err_reg, err_next;
    logic [MAP_W-1:0]    map_reg, map_next;
    logic                ov_reg, ov_next;
    logic [2*MAP_W-1:0]  od_reg, od_next;
    logic [1:0]          ou_reg, ou_next;

    logic [SREM_W-1:0]   srem_sh, trial;
    logic [TOT_W:0]      drem_sh;
    logic                qbit;
    logic [MAP_W-1:0]    map_now;
    logic                slot_free;
    logic                scored;

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign slot_free     = !ov_reg || m_axis_tready;
    assign scored        = last_reg && !err_reg;

    assign srem_sh = {srem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign drem_sh = {drem_reg[TOT_W-1:0], dvd_reg[SUM_W-1]};
    assign qbit    = drem_sh >= {1'b0, total};
    assign map_now = FULL_SCALE - root_reg;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    st_next = BK_SQRT;
                end
            end
            BK_SQRT:
            begin
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    st_next = BK_ACC;
                end
            end
            BK_ACC:
            begin
                st_next = scored ? BK_DIV : BK_DONE;
            end
            BK_DIV:
            begin
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    st_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (slot_free)
                begin
                    st_next = BK_IDLE;
                end
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        sum_next  = sum_reg;
        dvd_next  = dvd_reg;
        drem_next = drem_reg;
        last_next = last_reg;
        err_next  = err_reg;
        map_next  = map_reg;
        ov_next   = ov_reg;
        od_next   = od_reg;
        ou_next   = ou_reg;
        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        case (st_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    rad_next  = {pop_item.diff, {ROOT_W{1'b0}}};
                    srem_next = '0;
                    root_next = '0;
                    step_next = '0;
                    last_next = pop_item.last;
                    err_next  = pop_item.err;
                end
            end
            BK_SQRT:
            begin
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (srem_sh >= trial)
                begin
                    srem_next = srem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = srem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            BK_ACC:
            begin
                map_next  = map_now;
                step_next = '0;
                drem_next = '0;
                if (last_reg)
                begin
                    dvd_next = sum_reg + SUM_W'(map_now);
                    sum_next = '0;
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'(map_now);
                end
            end
            BK_DIV:
            begin
                step_next = step_reg + 1'b1;
                drem_next = qbit ? (drem_sh - {1'b0, total}) : drem_sh;
                dvd_next  = {dvd_reg[SUM_W-2:0], qbit};
            end
            BK_DONE:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    od_next = {(scored ? dvd_reg[MAP_W-1:0] : {MAP_W{1'b0}}), map_reg};
                    ou_next = {err_reg, scored};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        dvd_reg  <= dvd_next;
        drem_reg <= drem_next;
        last_reg <= last_next;
        err_reg  <= err_next;
        map_reg  <= map_next;
        od_reg   <= od_next;
        ou_reg   <= ou_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= BK_IDLE;
            step_reg <= '0;
            sum_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            step_reg <= step_next;
            sum_reg  <= sum_next;
            ov_reg   <= ov_next;
        end
    end

endmodule

// ===== sv/pixel_square_diff_similarity.sv =====
// ----------------------------------------------------------------------------
// pixel_square_diff_similarity
// Per-pixel square-difference similarity map with a frame-mean score.
// ----------------------------------------------------------------------------
// Path: each input beat passes the front, the queue and the back end's square
//   root, accumulate and output states; a scored last pixel also runs the divide.
// Flow: the back end finishes a beat, with its 16-step square root, before
//   it takes the next; a 4-entry queue lets the input side run ahead.
// Reset: frame width and height return to 64, pixel count and sum clear.
module pixel_square_diff_similarity #(
    parameter int unsigned MAX_FRAME_DIM = 4096,
    parameter int unsigned MIN_FRAME_DIM = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [2*psds_pkg::PIX_W-1:0]      s_axis_tdata,   // ref_pixel, test_pixel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*psds_pkg::MAP_W-1:0]      m_axis_tdata,   // map_value, frame_score
    output logic [1:0]                        m_axis_tuser,   // score_valid, size_error
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psds_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import psds_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_DIM * MAX_FRAME_DIM);
    localparam int unsigned TOT_W = $clog2(MAX_FRAME_DIM * MAX_FRAME_DIM + 1);

    psds_item_t       push_item, pop_item;
    logic             push, pop, full, empty;
    logic [TOT_W-1:0] total;

    psds_front #(
        .MAX_FRAME_DIM (MAX_FRAME_DIM),
        .MIN_FRAME_DIM (MIN_FRAME_DIM),
        .CNT_W         (CNT_W),
        .TOT_W         (TOT_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .push_item     (push_item),
        .full          (full),
        .total         (total)
    );

    psds_fifo #(
        .DEPTH (4)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (full),
        .empty     (empty)
    );

    psds_back #(
        .CNT_W (CNT_W),
        .TOT_W (TOT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop           (pop),
        .pop_item      (pop_item),
        .empty         (empty),
        .total         (total),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== sv/psds_checker.sv =====
// ----------------------------------------------------------------------------
// psds_checker
// Port-level checks on the result stream of the similarity block.
// ----------------------------------------------------------------------------
module psds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_score_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("score marked valid on a size error");

    a_score_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:16] == 16'd0)
        else $error("frame score nonzero without score valid");

    a_map_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'd65280)
        else $error("map value above full scale");

endmodule

bind pixel_square_diff_similarity psds_checker u_psds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
